@@ design/tlbpt_pkg.sv @@
// Package for the TLB page translator: widths, command codes, FSM states
// and the command struct between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package tlbpt_pkg;

   localparam int TLB_ENTRIES  = 32;
   localparam int VPAGE_BITS   = 8;
   localparam int PPAGE_BITS   = 20;
   localparam int OFFSET_BITS  = 12;

   localparam int VA_BITS      = 20;
   localparam int PA_BITS      = 32;
   localparam int CNT_BITS     = 32;
   localparam int REQ_VP_BITS  = 8;
   localparam int REQ_PP_BITS  = 20;

   localparam int PAGE_DEPTH   = 1 << VPAGE_BITS;
   localparam int SLOT_BITS    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int AGE_BITS     = SLOT_BITS;

   typedef enum logic [1:0] {
      CMD_TRANSLATE = 2'd0,
      CMD_MAP       = 2'd1,
      CMD_UNMAP     = 2'd2,
      CMD_FLUSH     = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctl_cmd_type;

endpackage

@@ design/tlbpt_req_if.sv @@
// Request channel interface: valid/ready handshake plus request payload.
// Depends on tlbpt_pkg.
`timescale 1ns / 1ps

interface tlbpt_req_if;
   import tlbpt_pkg::*;

   logic                   valid;
   logic                   ready;
   cmd_type                cmd;
   logic [VA_BITS-1:0]     virtual_address;
   logic [REQ_VP_BITS-1:0] virtual_page;
   logic [REQ_PP_BITS-1:0] physical_page;

   modport source (output valid, cmd, virtual_address, virtual_page, physical_page,
                   input ready);
   modport sink   (input valid, cmd, virtual_address, virtual_page, physical_page,
                   output ready);
endinterface

@@ design/tlbpt_rsp_if.sv @@
// Response channel interface: valid/ready handshake plus result payload.
// Depends on tlbpt_pkg.
`timescale 1ns / 1ps

interface tlbpt_rsp_if;
   import tlbpt_pkg::*;

   logic                valid;
   logic                ready;
   logic [PA_BITS-1:0]  physical_address;
   logic                success;
   logic                page_fault;
   logic                tlb_hit;
   logic [CNT_BITS-1:0] hit_count;
   logic [CNT_BITS-1:0] miss_count;
   logic [CNT_BITS-1:0] fault_count;

   modport source (output valid, physical_address, success, page_fault, tlb_hit,
                   hit_count, miss_count, fault_count, input ready);
   modport sink   (input valid, physical_address, success, page_fault, tlb_hit,
                   hit_count, miss_count, fault_count, output ready);
endinterface

@@ design/tlb_page_translate_top.sv @@
// Top level of the TLB page translator: controller plus datapath.
// Depends on tlbpt_pkg, tlbpt_req_if, tlbpt_rsp_if, tlbpt_ctrl, tlbpt_datapath.
//
//   channel   direction  handshake              payload
//   req_if    in         valid/ready            cmd, virtual_address, virtual_page,
//                                               physical_page
//   rsp_if    out        valid/ready            physical_address, success, page_fault,
//                                               tlb_hit, hit/miss/fault counts
//   csr_*     in         write enable, no wait  tlb_enabled (1 bit)
//
// Each request is accepted in ST_IDLE, which registers the request, the TLB
// tag compare, the free/victim slot and the page table read; ST_EXEC then
// updates LRU ranks, counters and tables and loads the result register.
// Reset is synchronous: TLB valid bits, page present flags, LRU ranks and the
// counters clear at once and the enable register reads 1; no clearing pass.
// A result waiting on rsp_if does not block the next request transfer; that
// request only stalls in ST_EXEC until the result register is free.
`timescale 1ns / 1ps

module tlb_page_translate_top (
   input  logic        clock,
   input  logic        reset,
   tlbpt_req_if.sink   req_if,
   tlbpt_rsp_if.source rsp_if,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import tlbpt_pkg::*;

   ctl_cmd_type ctl;

   // sequence one request at a time, hold results for the sink
   tlbpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .ctl       (ctl)
   );

   // lookup, LRU update, page table and counters
   tlbpt_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_cmd              (req_if.cmd),
      .req_virtual_address  (req_if.virtual_address),
      .req_virtual_page     (req_if.virtual_page),
      .req_physical_page    (req_if.physical_page),
      .rsp_physical_address (rsp_if.physical_address),
      .rsp_success          (rsp_if.success),
      .rsp_page_fault       (rsp_if.page_fault),
      .rsp_tlb_hit          (rsp_if.tlb_hit),
      .rsp_hit_count        (rsp_if.hit_count),
      .rsp_miss_count       (rsp_if.miss_count),
      .rsp_fault_count      (rsp_if.fault_count)
   );

endmodule

@@ design/tlbpt_ctrl.sv @@
// Controller FSM: sequences capture and commit of one request at a time and
// owns the response valid flag. Depends on tlbpt_pkg.
`timescale 1ns / 1ps

module tlbpt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tlbpt_pkg::ctl_cmd_type ctl
);
   import tlbpt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctl          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/tlbpt_datapath.sv @@
// Datapath: TLB slots with LRU ranks, page table (present flags and frame
// memory), saturating counters and the result register. Depends on tlbpt_pkg.
`timescale 1ns / 1ps

module tlbpt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  tlbpt_pkg::ctl_cmd_type          ctl,
   input  logic                            csr_write_enable,
   input  logic                            csr_write_data,
   input  tlbpt_pkg::cmd_type              req_cmd,
   input  logic [tlbpt_pkg::VA_BITS-1:0]   req_virtual_address,
   input  logic [tlbpt_pkg::REQ_VP_BITS-1:0] req_virtual_page,
   input  logic [tlbpt_pkg::REQ_PP_BITS-1:0] req_physical_page,
   output logic [tlbpt_pkg::PA_BITS-1:0]   rsp_physical_address,
   output logic                            rsp_success,
   output logic                            rsp_page_fault,
   output logic                            rsp_tlb_hit,
   output logic [tlbpt_pkg::CNT_BITS-1:0]  rsp_hit_count,
   output logic [tlbpt_pkg::CNT_BITS-1:0]  rsp_miss_count,
   output logic [tlbpt_pkg::CNT_BITS-1:0]  rsp_fault_count
);
   import tlbpt_pkg::*;

   localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(TLB_ENTRIES - 1);

   function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // configuration
   logic enabled_ff;

   // captured request
   cmd_type                cmd_ff;
   logic [VA_BITS-1:0]     va_ff;
   logic [VPAGE_BITS-1:0]  mvp_ff;
   logic [PPAGE_BITS-1:0]  mpp_ff;
   logic [TLB_ENTRIES-1:0] hit_vec_ff;
   logic [SLOT_BITS-1:0]   fill_slot_ff;
   logic                   present_rd_ff;
   logic [PPAGE_BITS-1:0]  frame_rd_ff;

   // TLB slots
   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [VPAGE_BITS-1:0]  vpage_ff [TLB_ENTRIES];
   logic [PPAGE_BITS-1:0]  ppage_ff [TLB_ENTRIES];
   logic [AGE_BITS-1:0]    age_ff   [TLB_ENTRIES];
   logic [AGE_BITS-1:0]    age_in   [TLB_ENTRIES];

   // page table
   logic [PAGE_DEPTH-1:0]  present_ff;
   logic [PPAGE_BITS-1:0]  frame_mem [PAGE_DEPTH];

   // counters
   logic [CNT_BITS-1:0]    hits_ff, hits_in;
   logic [CNT_BITS-1:0]    misses_ff, misses_in;
   logic [CNT_BITS-1:0]    faults_ff, faults_in;

   // lookup on the incoming request
   logic [VPAGE_BITS-1:0]  req_vp;
   logic [TLB_ENTRIES-1:0] match_vec;
   logic                   free_any;
   logic [SLOT_BITS-1:0]   free_idx;
   logic [SLOT_BITS-1:0]   victim_idx;

   // commit-side decode
   logic                   is_xlate, hit_any, do_hit, do_fill, do_fault;
   logic [SLOT_BITS-1:0]   hit_idx;
   logic [AGE_BITS-1:0]    hit_age;
   logic [PPAGE_BITS-1:0]  hit_ppage;
   logic [OFFSET_BITS-1:0] offset;
   logic [PA_BITS-1:0]     pa_in;
   logic                   ok_in;

   assign req_vp = req_virtual_address[OFFSET_BITS +: VPAGE_BITS];

   always_comb begin
      free_any   = ~&valid_ff;
      free_idx   = '0;
      victim_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         match_vec[i] = valid_ff[i] && (vpage_ff[i] == req_vp);
         if (!valid_ff[i]) free_idx = SLOT_BITS'(i);
         // ranks are a permutation when every slot is valid: oldest holds the top rank
         if (age_ff[i] == AGE_MAX) victim_idx = SLOT_BITS'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
      end else if (csr_write_enable) begin
         enabled_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff        <= req_cmd;
         va_ff         <= req_virtual_address;
         mvp_ff        <= req_virtual_page[VPAGE_BITS-1:0];
         mpp_ff        <= req_physical_page[PPAGE_BITS-1:0];
         hit_vec_ff    <= match_vec;
         fill_slot_ff  <= free_any ? free_idx : victim_idx;
         present_rd_ff <= present_ff[req_vp];
         frame_rd_ff   <= frame_mem[req_vp];
      end
      if (ctl.commit && cmd_ff == CMD_MAP) begin
         frame_mem[mvp_ff] <= mpp_ff;
      end
   end

   always_comb begin
      is_xlate  = (cmd_ff == CMD_TRANSLATE) && enabled_ff;
      hit_any   = |hit_vec_ff;
      hit_idx   = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec_ff[i]) hit_idx = SLOT_BITS'(i);
      end
      hit_age   = age_ff[hit_idx];
      hit_ppage = ppage_ff[hit_idx];
      do_hit    = is_xlate && hit_any;
      do_fill   = is_xlate && !hit_any && present_rd_ff;
      do_fault  = is_xlate && !hit_any && !present_rd_ff;
      offset    = va_ff[OFFSET_BITS-1:0];

      // LRU ranks: promote on hit and age the valid slots younger than it; on fill, age every other valid slot
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (do_hit) begin
            if (SLOT_BITS'(i) == hit_idx) age_in[i] = '0;
            else if (valid_ff[i] && age_ff[i] < hit_age) age_in[i] = age_ff[i] + 1'b1;
         end else if (do_fill) begin
            if (SLOT_BITS'(i) == fill_slot_ff) age_in[i] = '0;
            else if (valid_ff[i]) age_in[i] = age_ff[i] + 1'b1;
         end
      end

      hits_in   = do_hit ? sat_inc(hits_ff) : hits_ff;
      misses_in = (do_fill || do_fault) ? sat_inc(misses_ff) : misses_ff;
      faults_in = do_fault ? sat_inc(faults_ff) : faults_ff;

      pa_in = '0;
      ok_in = 1'b1;
      if (cmd_ff == CMD_TRANSLATE) begin
         if (!enabled_ff)  pa_in = PA_BITS'(va_ff);
         else if (do_hit)  pa_in = PA_BITS'({hit_ppage, offset});
         else if (do_fill) pa_in = PA_BITS'({frame_rd_ff, offset});
         else              ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         present_ff <= '0;
         hits_ff    <= '0;
         misses_ff  <= '0;
         faults_ff  <= '0;
         for (int i = 0; i < TLB_ENTRIES; i++) age_ff[i] <= '0;
      end else if (ctl.commit) begin
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         faults_ff <= faults_in;
         for (int i = 0; i < TLB_ENTRIES; i++) age_ff[i] <= age_in[i];
         case (cmd_ff)
            CMD_MAP:   present_ff[mvp_ff] <= 1'b1;
            CMD_UNMAP: present_ff[mvp_ff] <= 1'b0;
            CMD_FLUSH: valid_ff           <= '0;
            default: begin
               if (do_fill) valid_ff[fill_slot_ff] <= 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit && do_fill) begin
         vpage_ff[fill_slot_ff] <= va_ff[OFFSET_BITS +: VPAGE_BITS];
         ppage_ff[fill_slot_ff] <= frame_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_physical_address <= pa_in;
         rsp_success          <= ok_in;
         rsp_page_fault       <= do_fault;
         rsp_tlb_hit          <= do_hit;
         rsp_hit_count        <= hits_in;
         rsp_miss_count       <= misses_in;
         rsp_fault_count      <= faults_in;
      end
   end

endmodule

@@ design/tlbpt_checker.sv @@
// Port-level checks for the TLB page translator, bound to the top level.
// Depends on tlbpt_pkg and tlb_page_translate_top.
`timescale 1ns / 1ps

module tlbpt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tlbpt_pkg::PA_BITS-1:0]  rsp_physical_address,
   input logic                           rsp_success,
   input logic                           rsp_page_fault,
   input logic                           rsp_tlb_hit,
   input logic [tlbpt_pkg::CNT_BITS-1:0] rsp_hit_count
);
   import tlbpt_pkg::*;

   // one request in flight: no transfer in the cycle after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in work");

   // a fresh result follows a request transfer, via ST_EXEC and the result register
   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a request");

   // a TLB hit is a success and never a fault
   a_hit_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tlb_hit |-> rsp_success && !rsp_page_fault)
      else $error("inconsistent hit flags");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_physical_address)
         && $stable(rsp_success) && $stable(rsp_hit_count))
      else $error("stalled result changed");

endmodule

bind tlb_page_translate_top tlbpt_checker u_tlbpt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_if.valid),
   .req_ready            (req_if.ready),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_physical_address (rsp_if.physical_address),
   .rsp_success          (rsp_if.success),
   .rsp_page_fault       (rsp_if.page_fault),
   .rsp_tlb_hit          (rsp_if.tlb_hit),
   .rsp_hit_count        (rsp_if.hit_count)
);
